// ===== rtl/tetrahedron_circumcenter_core_assert.svh =====
// Assertion macros shared by the circumcenter RTL.
// Included by modules that check their own pipeline invariants.
`ifndef TETRAHEDRON_CIRCUMCENTER_CORE_ASSERT_SVH
`define TETRAHEDRON_CIRCUMCENTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define TCC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define TCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tcc_pkg.sv =====
// Shared types and widths for the tetrahedron circumcenter pipeline.
// No dependencies; used by every RTL module of the block.
package tcc_pkg;

    localparam int CW       = 32;   // coordinate width
    localparam int EW       = 33;   // edge width
    localparam int SQW      = 66;   // edge product width
    localparam int NW       = 67;   // normal and squared length width
    localparam int MW       = 68;   // multiplier operand width
    localparam int MLW      = 34;   // low slice of a multiplier operand
    localparam int PRW      = 136;  // wide product and numerator width
    localparam int DW       = 102;  // determinant width
    localparam int QW       = 33;   // quotient bits produced by the divider
    localparam int THR_W    = 62;
    localparam logic [THR_W-1:0] THR_RESET = 62'd281474977;
    localparam int NUM_STG  = 41;   // total pipeline stages
    localparam int DIV_STG  = QW;   // divider stages
    localparam int FLAG_STG = 7;    // stage that decides degeneracy and overflow
    localparam logic signed [35:0] SAT_MAX = 36'sd2147483647;
    localparam logic signed [35:0] SAT_MIN = -36'sd2147483648;

    typedef struct packed {
        logic signed [CW-1:0] a_x;
        logic signed [CW-1:0] a_y;
        logic signed [CW-1:0] a_z;
        logic signed [CW-1:0] b_x;
        logic signed [CW-1:0] b_y;
        logic signed [CW-1:0] b_z;
        logic signed [CW-1:0] c_x;
        logic signed [CW-1:0] c_y;
        logic signed [CW-1:0] c_z;
        logic signed [CW-1:0] d_x;
        logic signed [CW-1:0] d_y;
        logic signed [CW-1:0] d_z;
    } t_in_item;

    typedef struct packed {
        logic signed [CW-1:0] center_x;
        logic signed [CW-1:0] center_y;
        logic signed [CW-1:0] center_z;
        logic                 valid_res;
    } t_out_item;

    // Values that ride alongside the arithmetic stages.
    typedef struct packed {
        logic signed [CW-1:0] a_x;
        logic signed [CW-1:0] a_y;
        logic signed [CW-1:0] a_z;
        logic                 ok;
        logic [2:0]           neg;
        logic [2:0]           ovf;
    } t_side;

    typedef struct packed {
        logic [PRW-1:0] rem_x;
        logic [PRW-1:0] rem_y;
        logic [PRW-1:0] rem_z;
        logic [QW-1:0]  q_x;
        logic [QW-1:0]  q_y;
        logic [QW-1:0]  q_z;
        logic [DW-1:0]  dmag;
    } t_div_state;

endpackage

// ===== rtl/tcc_front.sv =====
// Front stages: edges, cross-product and square terms, normals and lengths.
// Depends on tcc_pkg.
module tcc_front (
    input  logic                             i_clk,
    input  logic [2:0]                       i_en,
    input  tcc_pkg::t_in_item                i_item,
    output logic signed [tcc_pkg::EW-1:0]    o_eb [3],
    output logic signed [tcc_pkg::NW-1:0]    o_n0 [3],
    output logic signed [tcc_pkg::NW-1:0]    o_n1 [3],
    output logic signed [tcc_pkg::NW-1:0]    o_n2 [3],
    output logic signed [tcc_pkg::NW-1:0]    o_lb,
    output logic signed [tcc_pkg::NW-1:0]    o_lc,
    output logic signed [tcc_pkg::NW-1:0]    o_ld
);

    logic signed [tcc_pkg::CW-1:0]  pa [3];
    logic signed [tcc_pkg::CW-1:0]  pb [3];
    logic signed [tcc_pkg::CW-1:0]  pc [3];
    logic signed [tcc_pkg::CW-1:0]  pd [3];
    logic signed [tcc_pkg::EW-1:0]  r_eb [3];
    logic signed [tcc_pkg::EW-1:0]  r_ec [3];
    logic signed [tcc_pkg::EW-1:0]  r_ed [3];
    logic signed [tcc_pkg::EW-1:0]  r_eb2 [3];
    logic signed [tcc_pkg::SQW-1:0] r_n0p [3];
    logic signed [tcc_pkg::SQW-1:0] r_n0m [3];
    logic signed [tcc_pkg::SQW-1:0] r_n1p [3];
    logic signed [tcc_pkg::SQW-1:0] r_n1m [3];
    logic signed [tcc_pkg::SQW-1:0] r_n2p [3];
    logic signed [tcc_pkg::SQW-1:0] r_n2m [3];
    logic signed [tcc_pkg::SQW-1:0] r_sb [3];
    logic signed [tcc_pkg::SQW-1:0] r_sc [3];
    logic signed [tcc_pkg::SQW-1:0] r_sd [3];

    always_comb begin
        pa[0] = i_item.a_x; pa[1] = i_item.a_y; pa[2] = i_item.a_z;
        pb[0] = i_item.b_x; pb[1] = i_item.b_y; pb[2] = i_item.b_z;
        pc[0] = i_item.c_x; pc[1] = i_item.c_y; pc[2] = i_item.c_z;
        pd[0] = i_item.d_x; pd[1] = i_item.d_y; pd[2] = i_item.d_z;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int k = 0; k < 3; k++) begin
                r_eb[k] <= tcc_pkg::EW'(pb[k]) - tcc_pkg::EW'(pa[k]);
                r_ec[k] <= tcc_pkg::EW'(pc[k]) - tcc_pkg::EW'(pa[k]);
                r_ed[k] <= tcc_pkg::EW'(pd[k]) - tcc_pkg::EW'(pa[k]);
            end
        end
    end

    // Component k of u x v is u[k+1]*v[k+2] - u[k+2]*v[k+1], indices mod 3.
    for (genvar k = 0; k < 3; k++) begin : g_comp
        localparam int I1 = (k + 1) % 3;
        localparam int I2 = (k + 2) % 3;

        always_ff @(posedge i_clk) begin
            if (i_en[1]) begin
                r_n0p[k] <= tcc_pkg::SQW'(r_eb[I1]) * tcc_pkg::SQW'(r_ec[I2]);
                r_n0m[k] <= tcc_pkg::SQW'(r_eb[I2]) * tcc_pkg::SQW'(r_ec[I1]);
                r_n1p[k] <= tcc_pkg::SQW'(r_ec[I1]) * tcc_pkg::SQW'(r_ed[I2]);
                r_n1m[k] <= tcc_pkg::SQW'(r_ec[I2]) * tcc_pkg::SQW'(r_ed[I1]);
                r_n2p[k] <= tcc_pkg::SQW'(r_ed[I1]) * tcc_pkg::SQW'(r_eb[I2]);
                r_n2m[k] <= tcc_pkg::SQW'(r_ed[I2]) * tcc_pkg::SQW'(r_eb[I1]);
                r_sb[k]  <= tcc_pkg::SQW'(r_eb[k]) * tcc_pkg::SQW'(r_eb[k]);
                r_sc[k]  <= tcc_pkg::SQW'(r_ec[k]) * tcc_pkg::SQW'(r_ec[k]);
                r_sd[k]  <= tcc_pkg::SQW'(r_ed[k]) * tcc_pkg::SQW'(r_ed[k]);
                r_eb2[k] <= r_eb[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[2]) begin
                o_n0[k] <= tcc_pkg::NW'(r_n0p[k]) - tcc_pkg::NW'(r_n0m[k]);
                o_n1[k] <= tcc_pkg::NW'(r_n1p[k]) - tcc_pkg::NW'(r_n1m[k]);
                o_n2[k] <= tcc_pkg::NW'(r_n2p[k]) - tcc_pkg::NW'(r_n2m[k]);
                o_eb[k] <= r_eb2[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            o_lb <= tcc_pkg::NW'(r_sb[0]) + tcc_pkg::NW'(r_sb[1]) + tcc_pkg::NW'(r_sb[2]);
            o_lc <= tcc_pkg::NW'(r_sc[0]) + tcc_pkg::NW'(r_sc[1]) + tcc_pkg::NW'(r_sc[2]);
            o_ld <= tcc_pkg::NW'(r_sd[0]) + tcc_pkg::NW'(r_sd[1]) + tcc_pkg::NW'(r_sd[2]);
        end
    end

endmodule

// ===== rtl/tcc_mul.sv =====
// Two-stage signed 68 x 68 multiplier built from four 34-bit partial products.
// Depends on tcc_pkg.
module tcc_mul (
    input  logic                           i_clk,
    input  logic [1:0]                     i_en,
    input  logic signed [tcc_pkg::MW-1:0]  i_a,
    input  logic signed [tcc_pkg::MW-1:0]  i_b,
    output logic signed [tcc_pkg::PRW-1:0] o_p
);

    localparam int HW = tcc_pkg::MW - tcc_pkg::MLW;
    localparam int XW = tcc_pkg::MW + 1;

    logic [tcc_pkg::MLW-1:0]      al;
    logic [tcc_pkg::MLW-1:0]      bl;
    logic signed [tcc_pkg::MLW:0] al_s;
    logic signed [tcc_pkg::MLW:0] bl_s;
    logic signed [HW-1:0]         ah;
    logic signed [HW-1:0]         bh;
    logic [tcc_pkg::MW-1:0]       r_ll;
    logic signed [XW-1:0]         r_lh;
    logic signed [XW-1:0]         r_hl;
    logic signed [tcc_pkg::MW-1:0] r_hh;

    assign al   = i_a[tcc_pkg::MLW-1:0];
    assign bl   = i_b[tcc_pkg::MLW-1:0];
    assign al_s = $signed({1'b0, al});
    assign bl_s = $signed({1'b0, bl});
    assign ah   = i_a[tcc_pkg::MW-1:tcc_pkg::MLW];
    assign bh   = i_b[tcc_pkg::MW-1:tcc_pkg::MLW];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_ll <= tcc_pkg::MW'(al) * tcc_pkg::MW'(bl);
            r_lh <= XW'(al_s) * XW'(bh);
            r_hl <= XW'(ah) * XW'(bl_s);
            r_hh <= tcc_pkg::MW'(ah) * tcc_pkg::MW'(bh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            o_p <= $signed({{(tcc_pkg::PRW - tcc_pkg::MW){1'b0}}, r_ll})
                 + ((tcc_pkg::PRW'(r_lh) + tcc_pkg::PRW'(r_hl)) <<< tcc_pkg::MLW)
                 + (tcc_pkg::PRW'(r_hh) <<< (2 * tcc_pkg::MLW));
        end
    end

endmodule

// ===== rtl/tcc_div_stg.sv =====
// One restoring-division stage: settles one quotient bit of all three axes.
// Depends on tcc_pkg.
module tcc_div_stg #(
    parameter int STEP = tcc_pkg::QW - 1
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  tcc_pkg::t_div_state i_st,
    output tcc_pkg::t_div_state o_st
);

    logic [tcc_pkg::PRW-1:0] dsh;
    tcc_pkg::t_div_state     n_st;

    assign dsh = tcc_pkg::PRW'(i_st.dmag) << STEP;

    always_comb begin
        n_st = i_st;
        if (i_st.rem_x >= dsh) begin
            n_st.rem_x   = i_st.rem_x - dsh;
            n_st.q_x[STEP] = 1'b1;
        end
        if (i_st.rem_y >= dsh) begin
            n_st.rem_y   = i_st.rem_y - dsh;
            n_st.q_y[STEP] = 1'b1;
        end
        if (i_st.rem_z >= dsh) begin
            n_st.rem_z   = i_st.rem_z - dsh;
            n_st.q_z[STEP] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_st <= n_st;
        end
    end

endmodule

// ===== rtl/tetrahedron_circumcenter_core.sv =====
// Top level of the tetrahedron circumcenter pipeline.
// Depends on tcc_pkg, tcc_front, tcc_mul, tcc_div_stg and the assertion header.
//
// Usage:
// - Input channel i_in_valid / o_in_ready carries four vertices (t_in_item) in
//   signed Q16.16. Output channel o_out_valid / i_out_ready carries the center
//   and a flag that is low for a degenerate tetrahedron (center = first vertex).
// - i_cfg_we writes the 62-bit determinant threshold from i_cfg_data at once.
// - The pipeline has 41 stages. One tetrahedron can enter every cycle while the
//   receiver takes results or some stage is empty; the 33 restoring-divider
//   stages, one quotient bit per stage, set the depth.
// - Every stage has its own valid bit and advances when it is empty or the
//   stage after it advances, so bubbles close up and input can be taken while a
//   finished result waits in the output register, if some stage is empty.
// - When the receiver stalls, full stages hold; nothing is dropped or repeated.
// - Synchronous reset empties the pipeline and loads the default threshold.
`include "tetrahedron_circumcenter_core_assert.svh"

module tetrahedron_circumcenter_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  tcc_pkg::t_in_item              i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output tcc_pkg::t_out_item             o_out_item,
    input  logic                           i_cfg_we,
    input  logic [tcc_pkg::THR_W-1:0]      i_cfg_data
);

    localparam int NS = tcc_pkg::NUM_STG;
    localparam int FS = tcc_pkg::FLAG_STG;

    logic [tcc_pkg::THR_W-1:0]      r_thr;
    logic [NS:1]                    r_v;
    logic [NS:1]                    en;

    logic signed [tcc_pkg::EW-1:0]  f_eb [3];
    logic signed [tcc_pkg::NW-1:0]  f_n0 [3];
    logic signed [tcc_pkg::NW-1:0]  f_n1 [3];
    logic signed [tcc_pkg::NW-1:0]  f_n2 [3];
    logic signed [tcc_pkg::NW-1:0]  f_lb;
    logic signed [tcc_pkg::NW-1:0]  f_lc;
    logic signed [tcc_pkg::NW-1:0]  f_ld;

    logic signed [tcc_pkg::PRW-1:0] m_det [3];
    logic signed [tcc_pkg::PRW-1:0] m_n1l [3];
    logic signed [tcc_pkg::PRW-1:0] m_n2l [3];
    logic signed [tcc_pkg::PRW-1:0] m_n0l [3];

    logic signed [tcc_pkg::DW-1:0]  r_det;
    logic signed [tcc_pkg::PRW-1:0] r_num [3];

    logic [tcc_pkg::DW-1:0]         adet;
    logic [tcc_pkg::PRW-1:0]        anum [3];
    logic [tcc_pkg::PRW-1:0]        dlim;

    tcc_pkg::t_side                 r_side [1:NS];
    tcc_pkg::t_side                 side_in [1:NS];
    tcc_pkg::t_div_state            r_div [0:tcc_pkg::DIV_STG];
    tcc_pkg::t_div_state            div_init;
    tcc_pkg::t_out_item             r_out;

    // A stage may load when the receiver is ready or some stage at or after it is empty.
    for (genvar k = 1; k <= NS; k++) begin : g_en
        assign en[k] = i_out_ready || !(&r_v[NS:k]);
    end

    assign o_in_ready  = en[1];
    assign o_out_valid = r_v[NS];
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= tcc_pkg::THR_RESET;
            r_v   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            if (en[1]) begin
                r_v[1] <= i_in_valid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    tcc_front u_front (
        .i_clk  (i_clk),
        .i_en   (en[3:1]),
        .i_item (i_in_item),
        .o_eb   (f_eb),
        .o_n0   (f_n0),
        .o_n1   (f_n1),
        .o_n2   (f_n2),
        .o_lb   (f_lb),
        .o_lc   (f_lc),
        .o_ld   (f_ld)
    );

    for (genvar k = 0; k < 3; k++) begin : g_mul
        tcc_mul u_det (
            .i_clk (i_clk), .i_en (en[5:4]),
            .i_a (tcc_pkg::MW'(f_eb[k])), .i_b (tcc_pkg::MW'(f_n1[k])), .o_p (m_det[k])
        );
        tcc_mul u_n1l (
            .i_clk (i_clk), .i_en (en[5:4]),
            .i_a (tcc_pkg::MW'(f_n1[k])), .i_b (tcc_pkg::MW'(f_lb)), .o_p (m_n1l[k])
        );
        tcc_mul u_n2l (
            .i_clk (i_clk), .i_en (en[5:4]),
            .i_a (tcc_pkg::MW'(f_n2[k])), .i_b (tcc_pkg::MW'(f_lc)), .o_p (m_n2l[k])
        );
        tcc_mul u_n0l (
            .i_clk (i_clk), .i_en (en[5:4]),
            .i_a (tcc_pkg::MW'(f_n0[k])), .i_b (tcc_pkg::MW'(f_ld)), .o_p (m_n0l[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_det <= tcc_pkg::DW'((m_det[0] + m_det[1] + m_det[2]) <<< 1);
            for (int k = 0; k < 3; k++) begin
                r_num[k] <= m_n1l[k] + m_n2l[k] + m_n0l[k];
            end
        end
    end

    // Magnitudes, the quotient overflow limit and the divider's initial state.
    always_comb begin
        adet = r_det[tcc_pkg::DW-1] ? tcc_pkg::DW'(-r_det) : tcc_pkg::DW'(r_det);
        dlim = tcc_pkg::PRW'(adet) << tcc_pkg::QW;
        for (int k = 0; k < 3; k++) begin
            anum[k] = r_num[k][tcc_pkg::PRW-1] ? tcc_pkg::PRW'(-r_num[k])
                                               : tcc_pkg::PRW'(r_num[k]);
        end
        div_init.rem_x = anum[0];
        div_init.rem_y = anum[1];
        div_init.rem_z = anum[2];
        div_init.q_x   = '0;
        div_init.q_y   = '0;
        div_init.q_z   = '0;
        div_init.dmag  = adet;
    end

    // Side line: the first vertex and the per-item flags.
    for (genvar k = 1; k <= NS; k++) begin : g_side
        if (k == 1) begin : g_first
            always_comb begin
                side_in[k].a_x = i_in_item.a_x;
                side_in[k].a_y = i_in_item.a_y;
                side_in[k].a_z = i_in_item.a_z;
                side_in[k].ok  = 1'b0;
                side_in[k].neg = '0;
                side_in[k].ovf = '0;
            end
        end else if (k == FS) begin : g_flag
            always_comb begin
                side_in[k]    = r_side[k-1];
                side_in[k].ok = adet > tcc_pkg::DW'(r_thr);
                for (int j = 0; j < 3; j++) begin
                    side_in[k].neg[j] = r_num[j][tcc_pkg::PRW-1] ^ r_det[tcc_pkg::DW-1];
                    side_in[k].ovf[j] = anum[j] >= dlim;
                end
            end
        end else begin : g_pass
            assign side_in[k] = r_side[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (en[k]) begin
                r_side[k] <= side_in[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[FS]) begin
            r_div[0] <= div_init;
        end
    end

    for (genvar j = 1; j <= tcc_pkg::DIV_STG; j++) begin : g_div
        tcc_div_stg #(
            .STEP (tcc_pkg::DIV_STG - j)
        ) u_stg (
            .i_clk (i_clk),
            .i_en  (en[FS + j]),
            .i_st  (r_div[j-1]),
            .o_st  (r_div[j])
        );
    end

    // Final stage: sign, add the first vertex, saturate.
    function automatic logic signed [tcc_pkg::CW-1:0] finish(
        input logic [tcc_pkg::QW-1:0]       q,
        input logic                         neg,
        input logic                         ovf,
        input logic signed [tcc_pkg::CW-1:0] a
    );
        logic signed [35:0] sq;
        logic signed [35:0] sum;
        sq = ovf ? (36'sd1 <<< tcc_pkg::QW) : $signed({3'b000, q});
        if (neg) begin
            sq = -sq;
        end
        sum = sq + 36'(a);
        if (sum > tcc_pkg::SAT_MAX) begin
            return tcc_pkg::CW'(tcc_pkg::SAT_MAX);
        end else if (sum < tcc_pkg::SAT_MIN) begin
            return tcc_pkg::CW'(tcc_pkg::SAT_MIN);
        end
        return tcc_pkg::CW'(sum);
    endfunction

    always_ff @(posedge i_clk) begin
        if (en[NS]) begin
            if (r_side[NS-1].ok) begin
                r_out.center_x <= finish(r_div[tcc_pkg::DIV_STG].q_x, r_side[NS-1].neg[0],
                                         r_side[NS-1].ovf[0], r_side[NS-1].a_x);
                r_out.center_y <= finish(r_div[tcc_pkg::DIV_STG].q_y, r_side[NS-1].neg[1],
                                         r_side[NS-1].ovf[1], r_side[NS-1].a_y);
                r_out.center_z <= finish(r_div[tcc_pkg::DIV_STG].q_z, r_side[NS-1].neg[2],
                                         r_side[NS-1].ovf[2], r_side[NS-1].a_z);
            end else begin
                r_out.center_x <= r_side[NS-1].a_x;
                r_out.center_y <= r_side[NS-1].a_y;
                r_out.center_z <= r_side[NS-1].a_z;
            end
            r_out.valid_res <= r_side[NS-1].ok;
        end
    end

    `TCC_ASSERT_NEXT(a_in_lands, i_clk, i_rst_n, (i_in_valid && o_in_ready), (r_v[1]), "accepted transfer did not reach stage one")
    `TCC_ASSERT_IMPLY(a_div_nonzero, i_clk, i_rst_n, (r_v[FS] && r_side[FS].ok), (r_div[0].dmag != '0), "divisor is zero for a valid tetrahedron")
    `TCC_ASSERT_IMPLY(a_rem_small, i_clk, i_rst_n, (r_v[NS-1] && r_side[NS-1].ok && !r_side[NS-1].ovf[0]), (r_div[tcc_pkg::DIV_STG].rem_x < tcc_pkg::PRW'(r_div[tcc_pkg::DIV_STG].dmag)), "division remainder not below divisor")

endmodule

// ===== verif/tb_tetrahedron_circumcenter_core.sv =====
// Self-checking testbench for tetrahedron_circumcenter_core: random and directed tetrahedra,
// an exact wide-integer circumcenter predictor and a scoreboard. Depends on tcc_pkg and the RTL.
`timescale 1ns / 1ps

module tb_tetrahedron_circumcenter_core;

    typedef logic signed [255:0] t_wide;

    typedef enum int {
        SHAPE_SMALL, SHAPE_TINY, SHAPE_FULL, SHAPE_FLAT, SHAPE_SAME
    } t_shape;

    // Holds the expected centers and recomputes each one exactly.
    class center_board;
        tcc_pkg::t_out_item exp_q[$];
        logic [61:0]  thr;
        int           errors;
        int           checked;
        int           flagged;

        function new();
            thr = tcc_pkg::THR_RESET;
            errors = 0;
            checked = 0;
            flagged = 0;
        endfunction

        function void cross3(input t_wide u[3], input t_wide v[3], output t_wide r[3]);
            r[0] = u[1] * v[2] - u[2] * v[1];
            r[1] = u[2] * v[0] - u[0] * v[2];
            r[2] = u[0] * v[1] - u[1] * v[0];
        endfunction

        function tcc_pkg::t_out_item circumcenter(tcc_pkg::t_in_item it);
            t_wide       av[3], eb[3], ec[3], ed[3], n0[3], n1[3], n2[3];
            t_wide       det, adet, lb, lc, ld, num, q, s;
            logic [255:0] mag;
            logic signed [31:0] res[3];
            tcc_pkg::t_out_item o;
            av[0] = t_wide'(it.a_x); av[1] = t_wide'(it.a_y); av[2] = t_wide'(it.a_z);
            eb[0] = t_wide'(it.b_x) - av[0];
            eb[1] = t_wide'(it.b_y) - av[1];
            eb[2] = t_wide'(it.b_z) - av[2];
            ec[0] = t_wide'(it.c_x) - av[0];
            ec[1] = t_wide'(it.c_y) - av[1];
            ec[2] = t_wide'(it.c_z) - av[2];
            ed[0] = t_wide'(it.d_x) - av[0];
            ed[1] = t_wide'(it.d_y) - av[1];
            ed[2] = t_wide'(it.d_z) - av[2];
            cross3(eb, ec, n0);
            cross3(ec, ed, n1);
            cross3(ed, eb, n2);
            det = 2 * (eb[0] * n1[0] + eb[1] * n1[1] + eb[2] * n1[2]);
            adet = (det < 0) ? -det : det;
            if (adet <= t_wide'({194'b0, thr})) begin
                o.center_x = it.a_x;
                o.center_y = it.a_y;
                o.center_z = it.a_z;
                o.valid_res = 1'b0;
                return o;
            end
            lb = eb[0] * eb[0] + eb[1] * eb[1] + eb[2] * eb[2];
            lc = ec[0] * ec[0] + ec[1] * ec[1] + ec[2] * ec[2];
            ld = ed[0] * ed[0] + ed[1] * ed[1] + ed[2] * ed[2];
            for (int k = 0; k < 3; k++) begin
                num = n1[k] * lb + n2[k] * lc + n0[k] * ld;
                mag = (num < 0) ? -num : num;
                q = t_wide'(mag / $unsigned(adet));
                // The quotient is truncated toward zero before the first vertex is added.
                if ((num < 0) != (det < 0)) q = -q;
                s = q + av[k];
                if (s > t_wide'(32'sh7FFFFFFF)) res[k] = 32'sh7FFFFFFF;
                else if (s < -t_wide'(64'sh80000000)) res[k] = 32'sh80000000;
                else res[k] = s[31:0];
            end
            o.center_x = res[0];
            o.center_y = res[1];
            o.center_z = res[2];
            o.valid_res = 1'b1;
            return o;
        endfunction

        function void note_input(tcc_pkg::t_in_item it);
            exp_q.push_back(circumcenter(it));
        endfunction

        function void check_result(tcc_pkg::t_out_item got);
            tcc_pkg::t_out_item e;
            if (exp_q.size() == 0) begin
                $error("center arrived with nothing expected: %h", got);
                errors++;
                return;
            end
            e = exp_q.pop_front();
            checked++;
            if (e.valid_res) flagged++;
            if (got.center_x !== e.center_x) begin
                $error("center_x expected %0d actual %0d", e.center_x, got.center_x);
                errors++;
            end
            if (got.center_y !== e.center_y) begin
                $error("center_y expected %0d actual %0d", e.center_y, got.center_y);
                errors++;
            end
            if (got.center_z !== e.center_z) begin
                $error("center_z expected %0d actual %0d", e.center_z, got.center_z);
                errors++;
            end
            if (got.valid_res !== e.valid_res) begin
                $error("valid_res expected %0b actual %0b", e.valid_res, got.valid_res);
                errors++;
            end
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    tcc_pkg::t_in_item          i_in_item = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    tcc_pkg::t_out_item         o_out_item;
    logic                       i_cfg_we = 1'b0;
    logic [tcc_pkg::THR_W-1:0]  i_cfg_data = '0;

    center_board        sb;
    bit                 quiet = 1'b0;
    int                 rx_hold = 0;
    int                 sent = 0;

    tetrahedron_circumcenter_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #40_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Receiver side: stalls come in bursts, none once the run goes quiet.
    always @(posedge i_clk) begin
        if (quiet) begin
            i_out_ready <= 1'b1;
        end else if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            rx_hold = $urandom_range(1, 17) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_item);
    end

    function automatic logic signed [31:0] offset(logic signed [31:0] base, int span);
        return base + $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic tcc_pkg::t_in_item make_tetra(t_shape shape);
        tcc_pkg::t_in_item t;
        int span;
        t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        if (shape == SHAPE_FULL) return t;
        span = (shape == SHAPE_TINY) ? 1024 : 262144;
        t.a_x = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        t.a_y = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        t.a_z = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        t.b_x = offset(t.a_x, span); t.b_y = offset(t.a_y, span); t.b_z = offset(t.a_z, span);
        t.c_x = offset(t.a_x, span); t.c_y = offset(t.a_y, span); t.c_z = offset(t.a_z, span);
        t.d_x = offset(t.a_x, span); t.d_y = offset(t.a_y, span); t.d_z = offset(t.a_z, span);
        if (shape == SHAPE_FLAT) begin
            // Fourth vertex in the plane of the first three.
            t.d_x = t.b_x + t.c_x - t.a_x;
            t.d_y = t.b_y + t.c_y - t.a_y;
            t.d_z = t.b_z + t.c_z - t.a_z;
        end else if (shape == SHAPE_SAME) begin
            t.b_x = t.a_x; t.b_y = t.a_y; t.b_z = t.a_z;
        end
        return t;
    endfunction

    task automatic send_tetra(tcc_pkg::t_in_item t);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= t;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(t);
        sent++;
    endtask

    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        while (sb.exp_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [tcc_pkg::THR_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.thr = v;
    endtask

    task automatic run_directed();
        tcc_pkg::t_in_item t;
        t = '0;
        send_tetra(t);
        t = {12{32'sh7FFFFFFF}};
        send_tetra(t);
        t = {12{32'sh80000000}};
        send_tetra(t);
        // Unit right-angle corner.
        t = '0;
        t.b_x = 32'sh00010000; t.c_y = 32'sh00010000; t.d_z = 32'sh00010000;
        send_tetra(t);
        // Same shape with opposite orientation, negative determinant.
        t = '0;
        t.b_x = 32'sh00010000; t.c_z = 32'sh00010000; t.d_y = 32'sh00010000;
        send_tetra(t);
        // Nearly flat: the first three vertices and a fourth just above their plane.
        t = '0;
        t.b_x = 32'sh40000000; t.c_y = 32'sh40000000;
        t.d_x = 32'sh40000000; t.d_y = 32'sh40000000; t.d_z = 32'sh00000100;
        send_tetra(t);
        t.b_x = 32'shC0000000; t.d_x = 32'shC0000000;
        send_tetra(t);
        // Corners of the coordinate cube mixed.
        t = {32'sh80000000, 32'sh80000000, 32'sh80000000,
             32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
             32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
             32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF};
        send_tetra(t);
        t = {32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
             32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
             32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
             32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000};
        send_tetra(t);
        // Raw-unit edges: determinant just below and just above the default threshold.
        t = '0;
        t.b_x = 32'sd519; t.c_y = 32'sd520; t.d_z = 32'sd521;
        send_tetra(t);
        t.b_x = 32'sd522; t.c_y = 32'sd522; t.d_z = 32'sd522;
        send_tetra(t);
        t = '0;
        t.b_x = 32'sd1; t.c_y = 32'sd1; t.d_z = 32'sd1;
        send_tetra(t);
        for (int i = 0; i < 4; i++) send_tetra(make_tetra(SHAPE_FLAT));
        for (int i = 0; i < 3; i++) send_tetra(make_tetra(SHAPE_SAME));
        for (int i = 0; i < 4; i++) send_tetra(make_tetra(SHAPE_TINY));
    endtask

    task automatic run_random(int count, bit last);
        int pick;
        for (int i = 0; i < count; i++) begin
            if (last && i == count / 2) quiet = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 40) send_tetra(make_tetra(SHAPE_SMALL));
            else if (pick < 65) send_tetra(make_tetra(SHAPE_TINY));
            else if (pick < 85) send_tetra(make_tetra(SHAPE_FULL));
            else if (pick < 95) send_tetra(make_tetra(SHAPE_FLAT));
            else send_tetra(make_tetra(SHAPE_SAME));
        end
    endtask

    initial begin
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_random(220, 1'b0);
        drain_pipeline();

        write_threshold('0);
        run_directed();
        run_random(200, 1'b0);
        drain_pipeline();

        write_threshold({tcc_pkg::THR_W{1'b1}});
        run_random(200, 1'b0);
        drain_pipeline();

        write_threshold(tcc_pkg::THR_W'({$urandom, $urandom}));
        run_random(200, 1'b0);
        drain_pipeline();

        write_threshold(tcc_pkg::THR_W'($urandom_range(0, 1 << 30)));
        run_random(200, 1'b0);
        drain_pipeline();

        write_threshold(tcc_pkg::THR_RESET);
        run_random(230, 1'b1);
        drain_pipeline();

        $display("Checked %0d circumcenters (%0d non-degenerate) from %0d tetrahedra",
                 sb.checked, sb.flagged, sent);
        $display("over six threshold settings, including zero, the maximum and the default.");
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
